// ===== rtl/ufe_pkg.sv =====
`default_nettype none

package ufe_pkg;

	// Table geometry
	localparam int NUM_NODES = 1024;
	localparam int NODE_W    = 10;
	localparam int SIZE_W    = 11;
	localparam int CNT_W     = 11;

	// Register map
	localparam int        ADDR_W         = 3;
	localparam logic      REG_NODE_COUNT = 1'b0;
	localparam int        CNT_RESET      = 1024;

	// Request codes
	localparam logic REQ_FIND  = 1'b0;
	localparam logic REQ_UNION = 1'b1;

	// Table access from the sequencer
	typedef struct packed {
		logic              p_we;
		logic [NODE_W-1:0] p_waddr;
		logic [NODE_W-1:0] p_wdata;
		logic [NODE_W-1:0] p_raddr;
		logic              s_we;
		logic [NODE_W-1:0] s_waddr;
		logic [SIZE_W-1:0] s_wdata;
		logic [NODE_W-1:0] s_raddr;
	} tbl_ctl_t;

	// Registered read data back to the sequencer
	typedef struct packed {
		logic [NODE_W-1:0] p_rdata;
		logic [SIZE_W-1:0] s_rdata;
	} tbl_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ufe_tables.sv =====
`default_nettype none

module ufe_tables
	import ufe_pkg::*;
(
	input  wire logic      clk,
	input  wire tbl_ctl_t  ctl,
	output tbl_rsp_t       rsp
);

	logic [NODE_W-1:0] parent_mem [NUM_NODES];
	logic [SIZE_W-1:0] size_mem   [NUM_NODES];
	logic [NODE_W-1:0] p_rdata_q;
	logic [SIZE_W-1:0] s_rdata_q;

	// Parent pointers: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.p_we) begin
			parent_mem[ctl.p_waddr] <= ctl.p_wdata;
		end
		p_rdata_q <= parent_mem[ctl.p_raddr];
	end

	// Set sizes: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.s_we) begin
			size_mem[ctl.s_waddr] <= ctl.s_wdata;
		end
		s_rdata_q <= size_mem[ctl.s_raddr];
	end

	assign rsp.p_rdata = p_rdata_q;
	assign rsp.s_rdata = s_rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ufe_seq.sv =====
`default_nettype none

module ufe_seq
	import ufe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CNT_W-1:0]  cnt_lim,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [NODE_W-1:0] node_a,
	input  wire logic [NODE_W-1:0] node_b,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [NODE_W-1:0]      root_a,
	output logic [NODE_W-1:0]      root_b,
	output logic                   joined,
	output logic [NODE_W-1:0]      result_root,
	output logic [SIZE_W-1:0]      set_size,
	output logic                   bad_node,
	output tbl_ctl_t               ctl,
	input  wire tbl_rsp_t          rsp
);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_CMP,
		ST_CMP_WR,
		ST_SZ_RDA,
		ST_SZ_RDB,
		ST_SZ_CMP,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [NODE_W-1:0] clr_q;
	logic [NODE_W-1:0] cur_q;
	logic [NODE_W-1:0] start_q;
	logic [NODE_W-1:0] root_q;
	logic [NODE_W-1:0] ra_q;
	logic [NODE_W-1:0] rb_q;
	logic [NODE_W-1:0] b_q;
	logic [SIZE_W-1:0] sa_q;
	logic              req_q;
	logic              phase_q;
	logic [NODE_W-1:0] res_root_q;
	logic [SIZE_W-1:0] res_size_q;
	logic              joined_q;
	logic              bad_q;
	logic              out_valid_q;
	logic [NODE_W-1:0] root_a_q;
	logic [NODE_W-1:0] root_b_q;
	logic              joined_out_q;
	logic [NODE_W-1:0] result_root_q;
	logic [SIZE_W-1:0] set_size_q;
	logic              bad_node_q;

	logic              accept;
	logic              bad_req;
	logic              a_larger;
	logic              merge;
	logic [SIZE_W-1:0] size_sum;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign bad_req  = ({1'b0, node_a} >= cnt_lim)
		|| ((req_type == REQ_UNION) && ({1'b0, node_b} >= cnt_lim));

	// Shared compare and adder for the merge step
	assign merge    = (req_q == REQ_UNION) && (ra_q != rb_q);
	assign a_larger = (sa_q > rsp.s_rdata);
	assign size_sum = sa_q + rsp.s_rdata;

	// Drive table reads and writes from the current step
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_CLR: begin
				ctl.p_we    = 1'b1;
				ctl.p_waddr = clr_q;
				ctl.p_wdata = clr_q;
				ctl.s_we    = 1'b1;
				ctl.s_waddr = clr_q;
				ctl.s_wdata = SIZE_W'(1);
			end
			ST_FIND_RD: ctl.p_raddr = cur_q;
			ST_FIND_CHK: ctl.p_raddr = rsp.p_rdata;
			ST_CMP: ctl.p_raddr = cur_q;
			ST_CMP_WR: begin
				ctl.p_we    = 1'b1;
				ctl.p_waddr = cur_q;
				ctl.p_wdata = root_q;
				ctl.p_raddr = rsp.p_rdata;
			end
			ST_SZ_RDA: ctl.s_raddr = ra_q;
			ST_SZ_RDB: ctl.s_raddr = rb_q;
			ST_SZ_CMP: begin
				if (merge) begin
					ctl.p_we    = 1'b1;
					ctl.s_we    = 1'b1;
					ctl.s_wdata = size_sum;
					if (a_larger) begin
						ctl.p_waddr = rb_q;
						ctl.p_wdata = ra_q;
						ctl.s_waddr = ra_q;
					end else begin
						ctl.p_waddr = ra_q;
						ctl.p_wdata = rb_q;
						ctl.s_waddr = rb_q;
					end
				end
			end
			default: ctl = '0;
		endcase
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop a result once the receiver takes it, unless the next one loads now
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NUM_NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						req_q   <= req_type;
						cur_q   <= node_a;
						start_q <= node_a;
						b_q     <= node_b;
						rb_q    <= '0;
						phase_q <= 1'b0;
						if (bad_req) begin
							ra_q       <= '0;
							res_root_q <= '0;
							res_size_q <= '0;
							joined_q   <= 1'b0;
							bad_q      <= 1'b1;
							state_q    <= ST_DONE;
						end else begin
							bad_q   <= 1'b0;
							state_q <= ST_FIND_RD;
						end
					end
				end
				ST_FIND_RD: state_q <= ST_FIND_CHK;
				ST_FIND_CHK: begin
					// walk up until a node points at itself
					if (rsp.p_rdata == cur_q) begin
						root_q  <= cur_q;
						cur_q   <= start_q;
						state_q <= ST_CMP;
					end else begin
						cur_q <= rsp.p_rdata;
					end
				end
				ST_CMP: begin
					if (cur_q == root_q) begin
						if (!phase_q) begin
							ra_q <= root_q;
							if (req_q == REQ_UNION) begin
								phase_q <= 1'b1;
								cur_q   <= b_q;
								start_q <= b_q;
								state_q <= ST_FIND_RD;
							end else begin
								state_q <= ST_SZ_RDA;
							end
						end else begin
							rb_q    <= root_q;
							state_q <= ST_SZ_RDA;
						end
					end else begin
						state_q <= ST_CMP_WR;
					end
				end
				ST_CMP_WR: begin
					// repoint the current node, advance to its old parent
					cur_q <= rsp.p_rdata;
					if (rsp.p_rdata == root_q) begin
						state_q <= ST_CMP;
					end
				end
				ST_SZ_RDA: state_q <= ST_SZ_RDB;
				ST_SZ_RDB: begin
					sa_q    <= rsp.s_rdata;
					state_q <= ST_SZ_CMP;
				end
				ST_SZ_CMP: begin
					if (merge) begin
						joined_q   <= 1'b1;
						res_size_q <= size_sum;
						res_root_q <= a_larger ? ra_q : rb_q;
					end else begin
						joined_q   <= 1'b0;
						res_size_q <= sa_q;
						res_root_q <= ra_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						root_a_q      <= ra_q;
						root_b_q      <= rb_q;
						joined_out_q  <= joined_q;
						result_root_q <= res_root_q;
						set_size_q    <= res_size_q;
						bad_node_q    <= bad_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign root_a      = root_a_q;
	assign root_b      = root_b_q;
	assign joined      = joined_out_q;
	assign result_root = result_root_q;
	assign set_size    = set_size_q;
	assign bad_node    = bad_node_q;

endmodule

`default_nettype wire

// ===== rtl/union_find_engine_unit.sv =====
`default_nettype none

// Disjoint-set engine over 1024 nodes with path compression and union by size.
// Input channel (in_valid/in_stall): one transaction carries req_type, node_a
// and node_b; a find resolves node_a, a union resolves both and merges sets.
// Output channel (out_valid/out_stall): one result transaction per request,
// held in an output register until taken; a stalled result does not block
// the next request, but that request cannot finish until the register frees.
// Steps: a root walk through ST_FIND_RD and ST_FIND_CHK, then a compression
// pass through ST_CMP and ST_CMP_WR (ST_CMP only when the node is its own
// root), then the size lookup, merge and output load. With union by size a
// path stays at most 10 links long. A union walks and compresses node_a, then
// node_b. The input is ready again in the cycle after the result is loaded.
// One request is in work at a time; the single read port of the parent table
// sets the pace of each link. A rejected index skips all table work and goes
// straight from acceptance to the output load.
// After reset the tables are cleared node by node (each node its own parent,
// every size one) with in_stall high; node_count resets to 1024 and is
// written through the APB port at byte address 0. The user must write it only
// while idle; the block itself does not enforce this.

module union_find_engine_unit
	import ufe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [NODE_W-1:0] node_a,
	input  wire logic [NODE_W-1:0] node_b,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [NODE_W-1:0]      root_a,
	output logic [NODE_W-1:0]      root_b,
	output logic                   joined,
	output logic [NODE_W-1:0]      result_root,
	output logic [SIZE_W-1:0]      set_size,
	output logic                   bad_node
);

	logic [CNT_W-1:0] node_count_q;
	logic [CNT_W-1:0] cnt_lim;
	logic             reg_hit;
	tbl_ctl_t         ctl;
	tbl_rsp_t         rsp;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1] == REG_NODE_COUNT);

	// Configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(CNT_RESET);
		end else if (psel && penable && pwrite && reg_hit) begin
			node_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// Register readback
	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = {{(32-CNT_W){1'b0}}, node_count_q};
		end
	end

	// Saturate the count at the table depth
	assign cnt_lim = (node_count_q > CNT_W'(NUM_NODES)) ? CNT_W'(NUM_NODES) : node_count_q;

	ufe_tables u_tables (
		.clk (clk),
		.ctl (ctl),
		.rsp (rsp)
	);

	ufe_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cnt_lim     (cnt_lim),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.node_a      (node_a),
		.node_b      (node_b),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.root_a      (root_a),
		.root_b      (root_b),
		.joined      (joined),
		.result_root (result_root),
		.set_size    (set_size),
		.bad_node    (bad_node),
		.ctl         (ctl),
		.rsp         (rsp)
	);

endmodule

`default_nettype wire
